// File: design/json_string_unescaper_assert.svh
// Assertion macros shared by the string unescaper modules.
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_DATA     = 3'd0;
    localparam status_t ST_DONE     = 3'd1;
    localparam status_t ST_NO_QUOTE = 3'd2;
    localparam status_t ST_BAD_ESC  = 3'd3;
    localparam status_t ST_TRUNC    = 3'd4;
    localparam status_t ST_UNTERM   = 3'd5;

    // Runs held between front and back
    localparam int JSU_FIFO_DEPTH = 4;

    // Most results one input byte can cause
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } result_t;

    // All results caused by one input byte; last_idx marks the final one
    typedef struct packed {
        logic [1:0]              last_idx;
        result_t [MAX_RES-1:0]   res;
    } run_t;

endpackage
`default_nettype wire

// File: design/jsu_front.sv
// Front end: takes text beats, runs the string parser and builds result runs.
`default_nettype none
module jsu_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    text_byte,
    input  wire logic          end_of_text,
    input  wire logic          text_valid,
    output logic               text_ready,
    input  wire logic          full,
    output logic               push,
    output jsu_pkg::run_t      run
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        M_WAIT = 4'b0001,
        M_STR  = 4'b0010,
        M_ESC  = 4'b0100,
        M_HEX  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } utf8_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    function automatic utf8_t utf8_enc(input logic [15:0] cp);
        utf8_t u;
        u = '0;
        if (cp[15:7] == 9'd0)
        begin
            u.len = 2'd1;
            u.b0  = {1'b0, cp[6:0]};
        end
        else if (cp[15:11] == 5'd0)
        begin
            u.len = 2'd2;
            u.b0  = {3'b110, cp[10:6]};
            u.b1  = {2'b10, cp[5:0]};
        end
        else
        begin
            u.len = 2'd3;
            u.b0  = {4'b1110, cp[15:12]};
            u.b1  = {2'b10, cp[11:6]};
            u.b2  = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] cp_reg, cp_next;
    logic        stop_reg, stop_next;

    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_dig;
    logic [15:0] cp_upd;
    utf8_t       utf;
    logic [7:0]  esc_byte;
    logic        esc_ok;
    logic [2:0]  n_res;
    run_t        run_c;

    assign text_ready = !full;
    assign accept     = text_valid && text_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_dig = 4'd0;
        if (text_byte inside {[8'h30:8'h39]})
            hex_dig = text_byte[3:0];
        else if (text_byte inside {[8'h61:8'h66], [8'h41:8'h46]})
            hex_dig = text_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    always_comb
    begin
        esc_ok = 1'b1;
        case (text_byte)
            CH_QUOTE: esc_byte = CH_QUOTE;
            CH_BSL:   esc_byte = CH_BSL;
            CH_SLASH: esc_byte = CH_SLASH;
            8'h62:    esc_byte = 8'h08;   // b
            8'h66:    esc_byte = 8'h0C;   // f
            8'h6E:    esc_byte = 8'h0A;   // n
            8'h72:    esc_byte = 8'h0D;   // r
            8'h74:    esc_byte = 8'h09;   // t
            default:
            begin
                esc_byte = 8'h00;
                esc_ok   = 1'b0;
            end
        endcase
    end

    assign cp_upd = (!stop_reg && hex_ok) ? {cp_reg[11:0], hex_dig} : cp_reg;
    assign utf    = utf8_enc(cp_upd);

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        cp_next   = cp_reg;
        stop_next = stop_reg;
        run_c     = '0;
        n_res     = 3'd0;
        case (mode_reg)
            M_WAIT:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    if (end_of_text)
                    begin
                        run_c.res[0] = '{data: 8'h00, status: ST_UNTERM};
                        n_res        = 3'd1;
                    end
                    else
                        mode_next = M_STR;
                end
                else
                begin
                    run_c.res[0] = '{data: 8'h00, status: ST_NO_QUOTE};
                    n_res        = 3'd1;
                end
            end
            M_STR:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    run_c.res[0] = '{data: 8'h00, status: ST_DONE};
                    n_res        = 3'd1;
                    mode_next    = M_WAIT;
                end
                else if (text_byte == CH_BSL)
                begin
                    if (end_of_text)
                    begin
                        run_c.res[0] = '{data: 8'h00, status: ST_UNTERM};
                        n_res        = 3'd1;
                        mode_next    = M_WAIT;
                    end
                    else
                        mode_next = M_ESC;
                end
                else
                begin
                    run_c.res[0] = '{data: text_byte, status: ST_DATA};
                    n_res        = 3'd1;
                    if (end_of_text)
                    begin
                        run_c.res[1] = '{data: 8'h00, status: ST_UNTERM};
                        n_res        = 3'd2;
                        mode_next    = M_WAIT;
                    end
                end
            end
            M_ESC:
            begin
                if (esc_ok)
                begin
                    run_c.res[0] = '{data: esc_byte, status: ST_DATA};
                    n_res        = 3'd1;
                    if (end_of_text)
                    begin
                        run_c.res[1] = '{data: 8'h00, status: ST_UNTERM};
                        n_res        = 3'd2;
                        mode_next    = M_WAIT;
                    end
                    else
                        mode_next = M_STR;
                end
                else if (text_byte == 8'h75)   // 'u'
                begin
                    if (end_of_text)
                    begin
                        run_c.res[0] = '{data: 8'h00, status: ST_TRUNC};
                        n_res        = 3'd1;
                        mode_next    = M_WAIT;
                    end
                    else
                    begin
                        mode_next = M_HEX;
                        cnt_next  = 2'd0;
                        cp_next   = 16'h0000;
                        stop_next = 1'b0;
                    end
                end
                else
                begin
                    run_c.res[0] = '{data: 8'h00, status: ST_BAD_ESC};
                    n_res        = 3'd1;
                    mode_next    = M_WAIT;
                end
            end
            M_HEX:
            begin
                cp_next   = cp_upd;
                stop_next = stop_reg || !hex_ok;
                if (cnt_reg == 2'd3)
                begin
                    run_c.res[0] = '{data: utf.b0, status: ST_DATA};
                    run_c.res[1] = '{data: utf.b1, status: ST_DATA};
                    run_c.res[2] = '{data: utf.b2, status: ST_DATA};
                    n_res        = {1'b0, utf.len};
                    cnt_next     = 2'd0;
                    if (end_of_text)
                    begin
                        run_c.res[utf.len] = '{data: 8'h00, status: ST_UNTERM};
                        n_res              = {1'b0, utf.len} + 3'd1;
                        mode_next          = M_WAIT;
                    end
                    else
                        mode_next = M_STR;
                end
                else if (end_of_text)
                begin
                    run_c.res[0] = '{data: 8'h00, status: ST_TRUNC};
                    n_res        = 3'd1;
                    cnt_next     = 2'd0;
                    mode_next    = M_WAIT;
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            default:
                mode_next = M_WAIT;
        endcase
        run_c.last_idx = 2'(n_res - 3'd1);
    end

    assign push = accept && (n_res != 3'd0);
    assign run  = run_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_WAIT;
            cnt_reg  <= 2'd0;
            cp_reg   <= 16'h0000;
            stop_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            cp_reg   <= cp_next;
            stop_reg <= stop_next;
        end
    end

endmodule
`default_nettype wire

// File: design/jsu_fifo.sv
// Short run queue between front and back.
`default_nettype none
`include "json_string_unescaper_assert.svh"
module jsu_fifo #(
    parameter int DEPTH = jsu_pkg::JSU_FIFO_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  jsu_pkg::run_t      wr_run,
    output logic               full,
    input  wire logic          pop,
    output jsu_pkg::run_t      rd_run,
    output logic               empty
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    run_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full   = (count_reg == CNT_FULL);
    assign empty  = (count_reg == '0);
    assign rd_run = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
            if (push && !pop)
                count_reg <= count_reg + CNT_ONE;
            else if (pop && !push)
                count_reg <= count_reg - CNT_ONE;
        end
    end

    `JSU_ASSERT_IMPL(a_no_overflow, push, !full, "run pushed into full queue")
    `JSU_ASSERT_IMPL(a_no_underflow, pop, !empty, "run popped from empty queue")
    `JSU_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_FULL, "count past depth")

endmodule
`default_nettype wire

// File: design/jsu_back.sv
// Back end: plays out one run of results, one beat per cycle while res_ready is high.
`default_nettype none
`include "json_string_unescaper_assert.svh"
module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          empty,
    input  jsu_pkg::run_t      rd_run,
    output logic               pop,
    output logic [7:0]         out_byte,
    output logic [2:0]         status,
    output logic               last_of_run,
    output logic               res_valid,
    input  wire logic          res_ready
);
    import jsu_pkg::*;

    run_t       run_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       take;
    logic       last;

    assign last        = (idx_reg == run_reg.last_idx);
    assign take        = busy_reg && res_ready;
    assign pop         = !empty && (!busy_reg || (take && last));
    assign res_valid   = busy_reg;
    assign out_byte    = run_reg.res[idx_reg].data;
    assign status      = run_reg.res[idx_reg].status;
    assign last_of_run = last;

    always_ff @(posedge clk)
    begin
        if (pop)
            run_reg <= rd_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            if (last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    `JSU_ASSERT_NEXT(a_stall_holds, busy_reg && !res_ready, busy_reg && $stable(idx_reg), "stalled beat moved")

endmodule
`default_nettype wire

// File: design/json_string_unescaper.sv
// JSON string unescaper: text bytes in, decoded UTF-8 bytes and status beats out.
// First result of a byte passes the run queue and then the back end's run register before it is valid.
// Throughput: one text byte per cycle while the run queue is not full; results leave at one beat per cycle
//   while res_ready is high, and a burst of results is absorbed by a FIFO_DEPTH-run queue.
// Reset (rst_n low, asynchronous): parser waits for an opening quote, queue and output empty.
`default_nettype none
module json_string_unescaper #(
    parameter int FIFO_DEPTH = jsu_pkg::JSU_FIFO_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // text channel
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    input  wire logic        text_valid,
    output logic             text_ready,
    // result channel
    output logic [7:0]       out_byte,
    output logic [2:0]       status,
    output logic             last_of_run,
    output logic             res_valid,
    input  wire logic        res_ready
);
    import jsu_pkg::*;

    // Front parses each accepted byte into a run of up to four result beats.
    // Bytes yielding nothing (opening quote, backslash, the u after it, all but the last hex digit) push nothing.
    // Text input stalls only while the run queue is full.
    logic push;
    logic full;
    logic pop;
    logic empty;
    run_t wr_run;
    run_t rd_run;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .full        (full),
        .push        (push),
        .run         (wr_run)
    );

    // Run queue lets the parser keep taking bytes while a burst drains.
    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_run (wr_run),
        .full   (full),
        .pop    (pop),
        .rd_run (rd_run),
        .empty  (empty)
    );

    // Back holds the current run in a register and steps through its beats;
    // the next run loads on the same edge the last beat is taken.
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .rd_run      (rd_run),
        .pop         (pop),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

endmodule
`default_nettype wire
